@@ rtl/core/sct_pkg.sv @@
// Package for the sine, cosine and tangent evaluator.
// Holds widths, constants, coefficient tables, payload structs and the rounding shift.
// Depends on nothing.
package sct_pkg;

	localparam int WF          = 30;
	localparam int R_W         = 33;
	localparam int U_W         = 29;
	localparam int ACC_W       = 36;
	localparam int HP_W        = 66;
	localparam int PM_W        = 69;
	localparam int PS_W        = 67;
	localparam int SC_W        = 34;
	localparam int NUM_W       = 60;
	localparam int QB          = 41;
	localparam int DV_W        = 76;
	localparam int TAN_FRAC    = 24;
	localparam int SIN_STEPS   = 8;
	localparam int COS_STEPS   = 9;
	localparam int QUEUE_DEPTH = 4;
	localparam int QA_W        = 2;

	localparam logic [31:0] INV_PI_Q32 = 32'h517C_C1B7;
	localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;
	localparam logic [QB-1:0] TAN_MAX     = 41'h07F_FFFF_FFFF;
	localparam logic [QB-1:0] TAN_NEG_MAX = 41'h080_0000_0000;
	localparam logic signed [ACC_W-1:0] ONE_Q = 36'sh0_4000_0000;

	localparam logic signed [ACC_W-1:0] SIN_COEF [SIN_STEPS] = '{
		-36'sd1766234505, 36'sd871601792, -36'sd204818212, 36'sd28076038,
		-36'sd2519085, 36'sd159374, -36'sd7490, 36'sd272
	};

	localparam logic signed [ACC_W-1:0] COS_COEF [COS_STEPS] = '{
		-36'sd5298703516, 36'sd4358008962, -36'sd1433727481, 36'sd252684340,
		-36'sd27709939, 36'sd2071865, -36'sd112354, 36'sd4620, -36'sd148
	};

	typedef enum logic [1:0] {
		MODE_SIN  = 2'd0,
		MODE_COS  = 2'd1,
		MODE_BOTH = 2'd2,
		MODE_TAN  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic                   xneg;
		logic                   odd;
		logic signed [R_W-1:0]  r;
	} item_t;

	typedef struct packed {
		mode_t                   mode;
		logic                    xneg;
		logic                    odd;
		logic signed [R_W-1:0]   r;
		logic [U_W-1:0]          u;
		logic signed [ACC_W-1:0] p;
		logic signed [ACC_W-1:0] q;
	} hw_t;

	typedef struct packed {
		mode_t             mode;
		logic [31:0]       sin_res;
		logic [31:0]       cos_res;
		logic              neg;
		logic              czero;
		logic              snz;
		logic              ovf;
		logic [SC_W-1:0]   cm;
		logic [NUM_W-1:0]  rem;
		logic [QB-1:0]     quo;
	} div_t;

	function automatic logic signed [79:0] rnd_sh(input logic signed [79:0] v,
		input int unsigned s);
		logic signed [79:0] h;
		if (s == 0) return v;
		h = 80'sd1 <<< (s - 1);
		return (v + h - (v < 0 ? 80'sd1 : 80'sd0)) >>> s;
	endfunction

	function automatic logic signed [ACC_W-1:0] cos_add(input int k);
		if (k < COS_STEPS - 1) return COS_COEF[COS_STEPS - 2 - k];
		return ONE_Q;
	endfunction

	function automatic logic signed [ACC_W-1:0] sin_add(input int k);
		if (k < SIN_STEPS - 1) return SIN_COEF[SIN_STEPS - 2 - k];
		return ONE_Q;
	endfunction

endpackage

@@ rtl/core/sct_front.sv @@
// Front end: accepts angle transactions and reduces them to half-turn parity and residual.
// Depends on sct_pkg.
module sct_front #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                item_valid,
	input  logic                item_ready,
	output sct_pkg::item_t      item
);

	localparam int R_W = sct_pkg::R_W;

	logic                v_s1, v_s2;
	sct_pkg::mode_t      mode_s1, mode_s2;
	logic                xneg_s1, xneg_s2;
	logic [31:0]         mag_s1;
	logic [63:0]         prod_s2;
	logic                en1, en2;
	logic [63:0]         t;
	logic [31:0]         frac;
	logic                up;
	logic signed [R_W-1:0] r;

	assign en2      = !v_s2 || item_ready;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			mode_s1 <= sct_pkg::mode_t'(s_tuser);
			xneg_s1 <= s_tdata[31];
			mag_s1  <= s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
		end
		if (en2 && v_s1) begin
			mode_s2 <= mode_s1;
			xneg_s2 <= xneg_s1;
			prod_s2 <= 64'(mag_s1) * 64'(sct_pkg::INV_PI_Q32);
		end
	end

	always_comb begin
		t    = (prod_s2 + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
		frac = t[31:0];
		up   = (frac > 32'h8000_0000) || (frac == 32'h8000_0000 && t[32]);
		r    = {1'b0, frac} - (up ? 33'h1_0000_0000 : 33'h0);
	end

	assign item_valid = v_s2;
	assign item       = '{mode: mode_s2, xneg: xneg_s2, odd: t[32] ^ up, r: r};

endmodule

@@ rtl/core/sct_queue.sv @@
// Short queue between the front end and the evaluation pipeline.
// Depends on sct_pkg.
module sct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sct_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output sct_pkg::item_t out_item
);

	localparam int QA_W  = sct_pkg::QA_W;
	localparam int DEPTH = sct_pkg::QUEUE_DEPTH;

	sct_pkg::item_t  mem_q [DEPTH];
	logic [QA_W-1:0] wr_q, rd_q;
	logic [QA_W:0]   cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != (QA_W + 1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

endmodule

@@ rtl/core/sct_div.sv @@
// Pipelined restoring divider for the tangent quotient, one quotient bit per stage.
// Depends on sct_pkg.
module sct_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  sct_pkg::div_t in_op,
	output logic          out_valid,
	output sct_pkg::div_t out_op
);

	localparam int QB    = sct_pkg::QB;
	localparam int DV_W  = sct_pkg::DV_W;
	localparam int NUM_W = sct_pkg::NUM_W;

	logic [QB:0]   v_s;
	sct_pkg::div_t st_s [QB+1];
	sct_pkg::div_t first;

	always_comb begin
		first     = in_op;
		first.quo = '0;
		first.ovf = DV_W'(in_op.rem) >= (DV_W'(in_op.cm) << QB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) st_s[0] <= first;
	end

	for (genvar j = 1; j <= QB; j++) begin : g_stage
		localparam int K = QB - j;
		logic [DV_W-1:0] d;
		logic            ge;
		sct_pkg::div_t   nx;

		always_comb begin
			d  = DV_W'(st_s[j-1].cm) << K;
			ge = DV_W'(st_s[j-1].rem) >= d;
			nx = st_s[j-1];
			if (ge) begin
				nx.rem    = st_s[j-1].rem - d[NUM_W-1:0];
				nx.quo[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) st_s[j] <= nx;
		end
	end

	assign out_valid = v_s[QB];
	assign out_op    = st_s[QB];

endmodule

@@ rtl/core/sct_back.sv @@
// Back end: Horner pipelines for both series, sign fix-up, tangent divide and output register.
// Depends on sct_pkg and sct_div.
module sct_back #(
	parameter int RESULT_FRAC_BITS = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  sct_pkg::item_t item,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [103:0]   m_tdata,
	output logic [0:0]     m_tuser
);

	localparam int WF    = sct_pkg::WF;
	localparam int U_W   = sct_pkg::U_W;
	localparam int ACC_W = sct_pkg::ACC_W;
	localparam int HP_W  = sct_pkg::HP_W;
	localparam int PM_W  = sct_pkg::PM_W;
	localparam int PS_W  = sct_pkg::PS_W;
	localparam int SC_W  = sct_pkg::SC_W;
	localparam int NUM_W = sct_pkg::NUM_W;
	localparam int QB    = sct_pkg::QB;
	localparam int NSTEP = sct_pkg::COS_STEPS;

	function automatic logic [31:0] to_res(input logic signed [SC_W-1:0] v);
		logic signed [79:0] w;
		logic signed [79:0] lim;
		w   = sct_pkg::rnd_sh(80'(v), WF - RESULT_FRAC_BITS);
		lim = 80'sd1 <<< RESULT_FRAC_BITS;
		if (w > lim) w = lim;
		if (w < -lim) w = -lim;
		return w[31:0];
	endfunction

	logic                   en;
	logic                   v_s0;
	sct_pkg::item_t         it_s0;
	logic signed [HP_W-1:0] sq_s0;
	logic signed [79:0]     u80;
	logic [NSTEP:0]         va_s;
	sct_pkg::hw_t           hacc_s [NSTEP+1];

	assign en         = !m_tvalid || m_tready;
	assign item_ready = en;
	assign u80        = sct_pkg::rnd_sh(80'(sq_s0), 34);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0    <= 1'b0;
			va_s[0] <= 1'b0;
		end else if (en) begin
			v_s0    <= item_valid;
			va_s[0] <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s0          <= item;
			sq_s0          <= HP_W'(item.r) * HP_W'(item.r);
			hacc_s[0].mode <= it_s0.mode;
			hacc_s[0].xneg <= it_s0.xneg;
			hacc_s[0].odd  <= it_s0.odd;
			hacc_s[0].r    <= it_s0.r;
			hacc_s[0].u    <= u80[U_W-1:0];
			hacc_s[0].p    <= sct_pkg::SIN_COEF[sct_pkg::SIN_STEPS-1];
			hacc_s[0].q    <= sct_pkg::COS_COEF[sct_pkg::COS_STEPS-1];
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_h
		logic                    vm_s;
		sct_pkg::hw_t            hm_s;
		logic signed [HP_W-1:0]  pq_s;
		logic signed [79:0]      rq;
		logic signed [ACC_W-1:0] np;
		sct_pkg::hw_t            nx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vm_s      <= 1'b0;
				va_s[k+1] <= 1'b0;
			end else if (en) begin
				vm_s      <= va_s[k];
				va_s[k+1] <= vm_s;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hm_s        <= hacc_s[k];
				pq_s        <= HP_W'(hacc_s[k].q) * HP_W'($signed({1'b0, hacc_s[k].u}));
				hacc_s[k+1] <= nx;
			end
		end

		assign rq = sct_pkg::rnd_sh(80'(pq_s), WF);

		if (k < sct_pkg::SIN_STEPS) begin : g_p
			logic signed [HP_W-1:0] pp_s;
			logic signed [79:0]     rp;

			always_ff @(posedge clk) begin
				if (en) pp_s <= HP_W'(hacc_s[k].p) * HP_W'($signed({1'b0, hacc_s[k].u}));
			end

			assign rp = sct_pkg::rnd_sh(80'(pp_s), WF);
			assign np = rp[ACC_W-1:0] + sct_pkg::sin_add(k);
		end else begin : g_pass
			assign np = hm_s.p;
		end

		always_comb begin
			nx   = hm_s;
			nx.q = rq[ACC_W-1:0] + sct_pkg::cos_add(k);
			nx.p = np;
		end
	end

	logic                   v_m1, v_m2, v_m3;
	sct_pkg::hw_t           h_m1, h_m2, h_m3;
	logic signed [PM_W-1:0] pm_m1;
	logic signed [SC_W-1:0] m_m2;
	logic signed [PS_W-1:0] ps_m3;
	logic signed [79:0]     m80;

	assign m80 = sct_pkg::rnd_sh(80'(pm_m1), WF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m1 <= va_s[NSTEP];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_m1  <= hacc_s[NSTEP];
			pm_m1 <= PM_W'(hacc_s[NSTEP].p) * PM_W'($signed({1'b0, sct_pkg::PI_Q30}));
			h_m2  <= h_m1;
			m_m2  <= m80[SC_W-1:0];
			h_m3  <= h_m2;
			ps_m3 <= PS_W'(h_m2.r) * PS_W'(m_m2);
		end
	end

	logic signed [79:0]     s80;
	logic signed [SC_W-1:0] s, c;
	logic [SC_W-1:0]        sm, cm;
	sct_pkg::div_t          dv_in, dv_out;
	logic                   dv_out_valid;

	always_comb begin
		s80 = sct_pkg::rnd_sh(80'(ps_m3), 32);
		s   = s80[SC_W-1:0];
		if (h_m3.odd ^ h_m3.xneg) s = -s;
		c   = h_m3.odd ? -h_m3.q[SC_W-1:0] : h_m3.q[SC_W-1:0];
		sm  = s[SC_W-1] ? SC_W'(-s) : SC_W'(s);
		cm  = c[SC_W-1] ? SC_W'(-c) : SC_W'(c);
		dv_in.mode    = h_m3.mode;
		dv_in.sin_res = (h_m3.mode == sct_pkg::MODE_SIN || h_m3.mode == sct_pkg::MODE_BOTH)
			? to_res(s) : 32'd0;
		dv_in.cos_res = (h_m3.mode == sct_pkg::MODE_COS || h_m3.mode == sct_pkg::MODE_BOTH)
			? to_res(c) : 32'd0;
		dv_in.czero   = c == '0;
		dv_in.snz     = sm != '0;
		dv_in.neg     = dv_in.czero ? s[SC_W-1] : (s[SC_W-1] ^ c[SC_W-1]);
		dv_in.ovf     = 1'b0;
		dv_in.cm      = dv_in.czero ? SC_W'(1) : cm;
		dv_in.rem     = (NUM_W'(sm) << sct_pkg::TAN_FRAC) + NUM_W'(cm >> 1);
		dv_in.quo     = '0;
	end

	sct_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_m3),
		.in_op     (dv_in),
		.out_valid (dv_out_valid),
		.out_op    (dv_out)
	);

	logic [QB-1:0] mq;
	logic          big, flag;
	logic [39:0]   tn;

	always_comb begin
		if (dv_out.czero) begin
			flag = 1'b1;
			big  = 1'b0;
			mq   = dv_out.snz ? sct_pkg::TAN_NEG_MAX : '0;
		end else begin
			flag = 1'b0;
			big  = dv_out.ovf;
			mq   = dv_out.quo;
		end
		if (!dv_out.neg && (big || mq > sct_pkg::TAN_MAX)) begin
			mq   = sct_pkg::TAN_MAX;
			flag = 1'b1;
		end else if (dv_out.neg && (big || mq > sct_pkg::TAN_NEG_MAX)) begin
			mq   = sct_pkg::TAN_NEG_MAX;
			flag = 1'b1;
		end
		tn = dv_out.neg ? (~mq[39:0] + 40'd1) : mq[39:0];
		if (dv_out.mode != sct_pkg::MODE_TAN) begin
			tn   = '0;
			flag = 1'b0;
		end
	end

	logic         out_v_q;
	logic [103:0] out_d_q;
	logic         out_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_out_valid;
	end

	always_ff @(posedge clk) begin
		if (en && dv_out_valid) begin
			out_d_q <= {tn, dv_out.cos_res, dv_out.sin_res};
			out_u_q <= flag;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_d_q;
	assign m_tuser[0] = out_u_q;

endmodule

@@ rtl/core/sin_cos_tan_evaluator.sv @@
// Throughput: one transaction per cycle unless m_tready stalls the output;
// every multiply and each tangent quotient bit has a pipeline stage of its own,
// and a four-entry queue decouples front and back.
// Reset: arst_n clears all valid flags and queue pointers at once; no clearing pass.
// Top level of the evaluator: front end, queue and back end.
// Depends on sct_pkg, sct_front, sct_queue, sct_back.
module sin_cos_tan_evaluator #(
	parameter int ANGLE_FRAC_BITS  = 24,
	parameter int RESULT_FRAC_BITS = 30
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // [31:0] angle
	input  logic [1:0]   s_tuser,  // [1:0] mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // [31:0] sine, [63:32] cosine, [103:64] tangent
	output logic [0:0]   m_tuser   // [0] tan_clipped
);

	logic           f_valid, f_ready;
	sct_pkg::item_t f_item;
	logic           q_valid, q_ready;
	sct_pkg::item_t q_item;

	sct_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	sct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	sct_back #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

@@ rtl/core/sct_checker.sv @@
// Port-level checks for the evaluator's result stream, bound to the top level.
// Depends on sin_cos_tan_evaluator.
module sct_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [0:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	a_tan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[63:0] != 64'd0 |-> m_tdata[103:64] == 40'd0 && !m_tuser[0])
		else $error("tangent set together with sine or cosine");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:0]) <= 32'sd1073741824
			&& $signed(m_tdata[31:0]) >= -32'sd1073741824
			&& $signed(m_tdata[63:32]) <= 32'sd1073741824
			&& $signed(m_tdata[63:32]) >= -32'sd1073741824)
		else $error("sine or cosine out of range");

endmodule

bind sin_cos_tan_evaluator sct_checker u_sct_checker (.*);

@@ tb/sv/sin_cos_tan_evaluator_checker.sv @@
// Checker for the sine, cosine and tangent evaluator: watches both stream channels,
// computes the expected trig results of each accepted angle and compares them.
// Depends on sct_pkg for the mode codes.
module sin_cos_tan_evaluator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [31:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] sine;
		logic [31:0] cosine;
		logic [39:0] tangent;
		logic        clipped;
	} trig_t;

	localparam longint SIN_K [8] = '{-64'sd1766234505, 64'sd871601792, -64'sd204818212,
		64'sd28076038, -64'sd2519085, 64'sd159374, -64'sd7490, 64'sd272};
	localparam longint COS_K [9] = '{-64'sd5298703516, 64'sd4358008962, -64'sd1433727481,
		64'sd252684340, -64'sd27709939, 64'sd2071865, -64'sd112354, 64'sd4620, -64'sd148};
	localparam longint TAN_LIM = 64'd549755813887;

	trig_t trig_queue [$];

	function automatic longint round_shift(input longint v, input int s);
		longint m;
		if (s == 0) return v;
		if (v >= 0) return (v + (64'sd1 <<< (s - 1))) >>> s;
		m = (-v + (64'sd1 <<< (s - 1))) >>> s;
		return -m;
	endfunction

	function automatic logic [31:0] clamp_q30(input longint v);
		if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
		if (v < -(64'sd1 <<< 30)) v = -(64'sd1 <<< 30);
		return v[31:0];
	endfunction

	function automatic trig_t eval_trig(input sct_pkg::mode_t mode, input logic [31:0] angle);
		trig_t res;
		logic xneg, up, odd, neg;
		longint unsigned mag, t, whole, frac, n, sm, cm, mq;
		longint r, u, p, q, m, s, c;
		xneg = angle[31];
		mag = xneg ? (64'd1 << 32) - angle : angle;
		t = (mag * 64'h517CC1B7 + (64'd1 << 23)) >> 24;
		whole = t >> 32;
		frac = t & 64'hFFFF_FFFF;
		up = frac > 64'h8000_0000 || (frac == 64'h8000_0000 && whole[0]);
		n = up ? whole + 1 : whole;
		r = up ? longint'(frac) - (64'sd1 <<< 32) : longint'(frac);
		odd = n[0];
		u = round_shift(r * r, 34);
		p = SIN_K[7];
		for (int i = 6; i >= 0; i--) p = round_shift(p * u, 30) + SIN_K[i];
		p = round_shift(p * u, 30) + (64'sd1 <<< 30);
		q = COS_K[8];
		for (int i = 7; i >= 0; i--) q = round_shift(q * u, 30) + COS_K[i];
		q = round_shift(q * u, 30) + (64'sd1 <<< 30);
		m = round_shift(p * 64'sd3373259426, 30);
		s = round_shift(r * m, 32);
		c = q;
		if (odd != xneg) s = -s;
		if (odd) c = -c;
		res = '0;
		if (mode == sct_pkg::MODE_TAN) begin
			sm = s < 0 ? -s : s;
			if (c == 0) begin
				res.clipped = 1'b1;
				neg = s < 0;
				mq = (sm == 0) ? 0 : TAN_LIM + 1;
			end else begin
				cm = c < 0 ? -c : c;
				neg = (s < 0) != (c < 0);
				mq = ((sm << 24) + (cm >> 1)) / cm;
			end
			if (!neg && mq > TAN_LIM) begin
				mq = TAN_LIM;
				res.clipped = 1'b1;
			end else if (neg && mq > TAN_LIM + 1) begin
				mq = TAN_LIM + 1;
				res.clipped = 1'b1;
			end
			mq = neg ? -mq : mq;
			res.tangent = mq[39:0];
		end
		if (mode == sct_pkg::MODE_SIN || mode == sct_pkg::MODE_BOTH) res.sine = clamp_q30(s);
		if (mode == sct_pkg::MODE_COS || mode == sct_pkg::MODE_BOTH) res.cosine = clamp_q30(c);
		return res;
	endfunction

	assign pending = trig_queue.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		trig_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				trig_queue.push_back(eval_trig(sct_pkg::mode_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[103:64], m_tuser[0]};
				if (trig_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction %h", got);
				end else begin
					want = trig_queue.pop_front();
					if (want != got) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: sin %h/%h cos %h/%h tan %h/%h clip %b/%b",
								want.sine, got.sine, want.cosine, got.cosine,
								want.tangent, got.tangent, want.clipped, got.clipped);
					end
				end
			end
		end
	end

endmodule

@@ tb/sv/sin_cos_tan_evaluator_test.sv @@
// Top of the evaluator testbench: clock, reset, angle stimulus and result back-pressure.
// Depends on sct_pkg, sin_cos_tan_evaluator and sin_cos_tan_evaluator_checker.
module sin_cos_tan_evaluator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_ITEMS   = 150;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;
	logic         calm = 1'b0;
	logic         hold_off = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sin_cos_tan_evaluator u_dut (.*);

	sin_cos_tan_evaluator_checker u_checker (.*);

	task automatic send_angle(input sct_pkg::mode_t mode, input logic [31:0] angle);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= angle;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_angle();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0700_0000) - 32'h0380_0000;
			2: return 32'sd26353589 * ($signed($urandom_range(0, 160)) - 80)
				+ $urandom_range(0, 16) - 8;
			3: return 32'sd13176795 * ($signed($urandom_range(0, 320)) - 160)
				+ $urandom_range(0, 4) - 2;
			default: return $urandom_range(0, 64) - 32;
		endcase
	endfunction

	initial begin
		logic [31:0] corners [10];
		corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_FFFF, 32'h0324_3F6B, 32'hFCDB_C095, 32'h0192_1FB5,
			32'h0648_7ED5, 32'h0096_0000};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (corners[i])
			for (int k = 0; k < 4; k++) send_angle(sct_pkg::mode_t'(k), corners[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
			if (i == 200) hold_off <= 1'b1;
			send_angle(sct_pkg::mode_t'($urandom_range(0, 3)), pick_angle());
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off <= 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sct_pkg.sv
rtl/core/sct_front.sv
rtl/core/sct_queue.sv
rtl/core/sct_div.sv
rtl/core/sct_back.sv
rtl/core/sin_cos_tan_evaluator.sv
rtl/core/sct_checker.sv
tb/sv/sin_cos_tan_evaluator_checker.sv
tb/sv/sin_cos_tan_evaluator_test.sv
